[rtl/walsh_hadamard_transform_mod_defines.svh]
// assertion macros for the walsh-hadamard transform block
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef WALSH_HADAMARD_TRANSFORM_MOD_DEFINES_SVH
`define WALSH_HADAMARD_TRANSFORM_MOD_DEFINES_SVH
`ifndef SYNTHESIS
`define WHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define WHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WHT_ASSERT_IMP(lbl, ante, cons)
`define WHT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/wht_pkg.sv]
// shared constants, types and modular helpers for the walsh-hadamard transform block
// no dependencies
package wht_pkg;

    localparam int LOG_SIZE = 10;
    localparam int ADDR_W   = LOG_SIZE;
    localparam int DEPTH    = 1 << LOG_SIZE;
    localparam int HALF     = DEPTH / 2;
    localparam int PASS_W   = (LOG_SIZE > 1) ? $clog2(LOG_SIZE) : 1;
    localparam int DATA_W   = 30;
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 10;

    localparam logic [DATA_W-1:0] MODULUS = 30'd998244353;

    typedef enum logic [CMD_W-1:0] {
        OP_WRITE = 2'd0,
        OP_XFORM = 2'd1,
        OP_READ  = 2'd2
    } wht_op_t;

    typedef struct packed {
        logic accept;
        logic acc_wr;
        logic acc_rd;
        logic clr_step;
        logic rd_x;
        logic rd_y;
        logic wr_s;
        logic wr_d;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic xf_last;
        logic out_free;
    } sts_t;

    function automatic logic [DATA_W-1:0] reduce_mod(input logic [DATA_W-1:0] v);
        return (v >= MODULUS) ? v - MODULUS : v;
    endfunction

    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        logic [DATA_W:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, MODULUS};
        return (s >= {1'b0, MODULUS}) ? t[DATA_W-1:0] : s[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] d;
        d = a - b;
        return (a >= b) ? d : d + MODULUS;
    endfunction

    // pair number with a bit slotted in at the pass position
    function automatic logic [ADDR_W-1:0] pair_addr(input logic [ADDR_W-1:0] pair,
                                                    input logic [PASS_W-1:0] pass,
                                                    input logic              hi_bit);
        logic [ADDR_W-1:0] low_mask;
        low_mask = (ADDR_W'(1) << pass) - ADDR_W'(1);
        return ((pair & ~low_mask) << 1) | (pair & low_mask) | (ADDR_W'(hi_bit) << pass);
    endfunction

endpackage

[rtl/wht_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module wht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/wht_datapath.sv]
// datapath: vector ram, clear sweep, butterfly address counters, modular add/sub, result register
// depends on wht_pkg, wht_ram and the assertion macro header
`include "walsh_hadamard_transform_mod_defines.svh"
module wht_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wht_pkg::ctl_t               ctl,
    output wht_pkg::sts_t               sts,
    input  logic [wht_pkg::INDEX_W-1:0] index,
    input  logic [wht_pkg::DATA_W-1:0]  value,
    output logic [wht_pkg::DATA_W-1:0]  data,
    output logic                        out_valid,
    input  logic                        out_ready
);

    logic [wht_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [wht_pkg::ADDR_W-1:0] clr_cnt_next;
    logic [wht_pkg::ADDR_W-1:0] pair_reg;
    logic [wht_pkg::ADDR_W-1:0] pair_next;
    logic [wht_pkg::PASS_W-1:0] pass_reg;
    logic [wht_pkg::PASS_W-1:0] pass_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       is_rd_reg;
    logic [wht_pkg::DATA_W-1:0] x_reg;
    logic [wht_pkg::DATA_W-1:0] diff_reg;
    logic [wht_pkg::DATA_W-1:0] data_reg;

    logic [wht_pkg::ADDR_W-1:0] idx;
    logic [wht_pkg::ADDR_W-1:0] addr_x;
    logic [wht_pkg::ADDR_W-1:0] addr_y;
    logic                       pair_last;
    logic                       pass_last;
    logic                       ram_we;
    logic [wht_pkg::ADDR_W-1:0] ram_waddr;
    logic [wht_pkg::DATA_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [wht_pkg::ADDR_W-1:0] ram_raddr;
    logic [wht_pkg::DATA_W-1:0] ram_rdata;

    assign idx       = wht_pkg::ADDR_W'(index);
    assign addr_x    = wht_pkg::pair_addr(pair_reg, pass_reg, 1'b0);
    assign addr_y    = wht_pkg::pair_addr(pair_reg, pass_reg, 1'b1);
    assign pair_last = (pair_reg == wht_pkg::ADDR_W'(wht_pkg::HALF - 1));
    assign pass_last = (pass_reg == wht_pkg::PASS_W'(wht_pkg::LOG_SIZE - 1));

    assign sts.clr_last = (clr_cnt_reg == wht_pkg::ADDR_W'(wht_pkg::DEPTH - 1));
    assign sts.xf_last  = pair_last && pass_last;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign data      = data_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_x;
        ram_wdata = '0;
        if (ctl.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (ctl.acc_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx;
            ram_wdata = wht_pkg::reduce_mod(value);
        end
        else if (ctl.wr_s)
        begin
            ram_we    = 1'b1;
            ram_wdata = wht_pkg::add_mod(x_reg, ram_rdata);
        end
        else if (ctl.wr_d)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_y;
            ram_wdata = diff_reg;
        end
    end

    always_comb
    begin
        ram_re    = ctl.acc_rd || ctl.rd_x || ctl.rd_y;
        ram_raddr = addr_x;
        if (ctl.acc_rd)
        begin
            ram_raddr = idx;
        end
        else if (ctl.rd_y)
        begin
            ram_raddr = addr_y;
        end
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        pair_next      = pair_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        if (ctl.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + wht_pkg::ADDR_W'(1);
        end
        if (ctl.wr_d)
        begin
            if (pair_last)
            begin
                pair_next = '0;
                pass_next = pass_last ? '0 : pass_reg + wht_pkg::PASS_W'(1);
            end
            else
            begin
                pair_next = pair_reg + wht_pkg::ADDR_W'(1);
            end
        end
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            pair_reg      <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            pair_reg      <= pair_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            is_rd_reg <= ctl.acc_rd;
        end
        if (ctl.rd_y)
        begin
            x_reg <= ram_rdata;
        end
        if (ctl.wr_s)
        begin
            diff_reg <= wht_pkg::sub_mod(x_reg, ram_rdata);
        end
        if (ctl.out_load)
        begin
            data_reg <= is_rd_reg ? ram_rdata : '0;
        end
    end

    wht_ram #(
        .WIDTH (wht_pkg::DATA_W),
        .DEPTH (wht_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // only one source drives the ram write port
    `WHT_ASSERT_IMP(a_one_writer, 1'b1, $onehot0({ctl.clr_step, ctl.acc_wr, ctl.wr_s, ctl.wr_d}))

endmodule

[rtl/wht_ctrl.sv]
// controller: clear sweep, command decode, butterfly sequencing and result hand-off
// depends on wht_pkg and the assertion macro header
`include "walsh_hadamard_transform_mod_defines.svh"
module wht_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [wht_pkg::CMD_W-1:0] cmd,
    input  wht_pkg::sts_t             sts,
    output wht_pkg::ctl_t             ctl
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RDX   = 7'b0000100,
        S_RDY   = 7'b0001000,
        S_WRS   = 7'b0010000,
        S_WRD   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    case (cmd)
                        wht_pkg::OP_WRITE:
                        begin
                            ctl.acc_wr = 1'b1;
                            state_next = S_FIN;
                        end
                        wht_pkg::OP_READ:
                        begin
                            ctl.acc_rd = 1'b1;
                            state_next = S_FIN;
                        end
                        wht_pkg::OP_XFORM:
                        begin
                            state_next = S_RDX;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_RDX:
            begin
                ctl.rd_x   = 1'b1;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                ctl.rd_y   = 1'b1;
                state_next = S_WRS;
            end
            S_WRS:
            begin
                ctl.wr_s   = 1'b1;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                ctl.wr_d   = 1'b1;
                state_next = sts.xf_last ? S_FIN : S_RDX;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `WHT_ASSERT_IMP(a_load_free, ctl.out_load, sts.out_free)
    `WHT_ASSERT_NXT(a_sum_then_diff, state_reg == S_WRS, state_reg == S_WRD)
    `WHT_ASSERT_NXT(a_xf_ends, ctl.wr_d && sts.xf_last, state_reg == S_FIN)

endmodule

[rtl/walsh_hadamard_transform_mod.sv]
// top level of the xor walsh-hadamard transform block over residues mod 998244353
// depends on wht_pkg, wht_ctrl, wht_datapath (and through it wht_ram)
//
// input channel: cmd, index, value under in_valid / in_ready; one beat per command
//   write stores value (reduced mod p) at index, read fetches the entry at index,
//   transform runs every butterfly pass in place, an unused code does nothing
// output channel: data under out_valid / out_ready; exactly one beat per input beat,
//   the entry read for a read and zero for every other command
// hand-off: a write or read beat goes straight to the finish state, a transform beat
//   once the last butterfly is written; the result register is loaded from there
// busy: a new command is taken only in idle; a transform reads x, reads y, writes the
//   sum, then the difference per butterfly, set by the single write port of the ram
// reset: the vector is swept to zero one entry a cycle, with in_ready low; the result
//   register comes out of reset empty
// stall: a waiting result stays in its register; one more command is taken and
//   then held until the register frees, so in_ready drops while data waits
module walsh_hadamard_transform_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [wht_pkg::CMD_W-1:0]   cmd,
    input  logic [wht_pkg::INDEX_W-1:0] index,
    input  logic [wht_pkg::DATA_W-1:0]  value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [wht_pkg::DATA_W-1:0]  data
);

    wht_pkg::ctl_t ctl;
    wht_pkg::sts_t sts;

    wht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    wht_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .index     (index),
        .value     (value),
        .data      (data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

[tb/walsh_hadamard_transform_mod_tb.sv]
// testbench for the xor walsh-hadamard transform block: directed and random commands,
// with a scoreboard class that mirrors the residue vector and checks every data beat
// depends on wht_pkg and walsh_hadamard_transform_mod
`timescale 1ns / 1ps

module walsh_hadamard_transform_mod_tb;

    localparam logic [wht_pkg::CMD_W-1:0] OP_UNUSED = 2'd3;

    class wht_scoreboard;
        logic [wht_pkg::DATA_W-1:0] residues [wht_pkg::DEPTH];
        logic [wht_pkg::DATA_W-1:0] expected_data [$];
        int unsigned                fails;

        function new();
            foreach (residues[i])
                residues[i] = '0;
            fails = 0;
        endfunction

        function logic [wht_pkg::DATA_W-1:0] mod_sum(input logic [wht_pkg::DATA_W-1:0] a,
                                                     input logic [wht_pkg::DATA_W-1:0] b);
            logic [wht_pkg::DATA_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, wht_pkg::MODULUS})
                s = s - {1'b0, wht_pkg::MODULUS};
            return s[wht_pkg::DATA_W-1:0];
        endfunction

        function logic [wht_pkg::DATA_W-1:0] mod_diff(input logic [wht_pkg::DATA_W-1:0] a,
                                                      input logic [wht_pkg::DATA_W-1:0] b);
            logic [wht_pkg::DATA_W:0] d;
            if (a >= b)
                d = {1'b0, a} - {1'b0, b};
            else
                d = {1'b0, a} + {1'b0, wht_pkg::MODULUS} - {1'b0, b};
            return d[wht_pkg::DATA_W-1:0];
        endfunction

        // every butterfly pass, in place, spans doubling each pass
        function void butterflies();
            logic [wht_pkg::DATA_W-1:0] x;
            logic [wht_pkg::DATA_W-1:0] y;
            for (int span = 1; span < wht_pkg::DEPTH; span = span * 2)
                for (int base = 0; base < wht_pkg::DEPTH; base = base + 2 * span)
                    for (int k = 0; k < span; k++)
                    begin
                        x = residues[base + k];
                        y = residues[base + span + k];
                        residues[base + k]        = mod_sum(x, y);
                        residues[base + span + k] = mod_diff(x, y);
                    end
        endfunction

        function void note_command(input logic [wht_pkg::CMD_W-1:0]   c,
                                   input logic [wht_pkg::INDEX_W-1:0] idx,
                                   input logic [wht_pkg::DATA_W-1:0]  val);
            logic [wht_pkg::ADDR_W-1:0] slot;
            logic [wht_pkg::DATA_W-1:0] answer;
            slot   = idx[wht_pkg::ADDR_W-1:0];
            answer = '0;
            if (c == wht_pkg::OP_WRITE)
                residues[slot] = (val >= wht_pkg::MODULUS) ? val - wht_pkg::MODULUS : val;
            else if (c == wht_pkg::OP_XFORM)
                butterflies();
            else if (c == wht_pkg::OP_READ)
                answer = residues[slot];
            expected_data.push_back(answer);
        endfunction

        function void check_data(input logic [wht_pkg::DATA_W-1:0] got);
            logic [wht_pkg::DATA_W-1:0] want;
            if (expected_data.size() == 0)
            begin
                $error("unexpected beat: data actual %0d", got);
                fails++;
            end
            else
            begin
                want = expected_data.pop_front();
                if (got !== want)
                begin
                    $error("mismatch on data: expected %0d, actual %0d", want, got);
                    fails++;
                end
            end
        endfunction

        function int pending();
            return expected_data.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS  = 650;
    localparam int XFORM_BUDGET  = 20;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 50;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [wht_pkg::CMD_W-1:0]   cmd = '0;
    logic [wht_pkg::INDEX_W-1:0] index = '0;
    logic [wht_pkg::DATA_W-1:0]  value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [wht_pkg::DATA_W-1:0]  data;

    wht_scoreboard results = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          long_hold_req = 1'b0;

    walsh_hadamard_transform_mod u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(60_000_000);
        $display("simulation failed");
        $finish;
    end

    task automatic send_cmd(input logic [wht_pkg::CMD_W-1:0]   c,
                            input logic [wht_pkg::INDEX_W-1:0] idx,
                            input logic [wht_pkg::DATA_W-1:0]  val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        index    <= idx;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        results.note_command(c, idx, val);
    endtask

    // result side: check beats, then pick ready for the next edge
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                results.check_data(data);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic [wht_pkg::INDEX_W-1:0] written [$];
        logic [wht_pkg::INDEX_W-1:0] idx;
        logic [wht_pkg::DATA_W-1:0]  val;
        int unsigned                 xforms_left;
        int unsigned                 pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 68;

        // directed: extremes, unreduced values, unused code, transforms
        send_cmd(wht_pkg::OP_READ,  10'd5,    30'd0);
        send_cmd(wht_pkg::OP_WRITE, 10'd0,    30'd0);
        send_cmd(wht_pkg::OP_WRITE, 10'd1023, 30'h3FFF_FFFF);
        send_cmd(wht_pkg::OP_WRITE, 10'd1,    wht_pkg::MODULUS);
        send_cmd(wht_pkg::OP_WRITE, 10'd2,    wht_pkg::MODULUS - 30'd1);
        send_cmd(wht_pkg::OP_WRITE, 10'd512,  30'd12345);
        send_cmd(OP_UNUSED,         10'd1023, 30'h3FFF_FFFF);
        send_cmd(wht_pkg::OP_READ,  10'd1023, 30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd1,    30'h3FFF_FFFF);
        send_cmd(wht_pkg::OP_READ,  10'd2,    30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd0,    30'd0);
        send_cmd(OP_UNUSED,         10'd0,    30'd0);
        send_cmd(wht_pkg::OP_XFORM, 10'd1023, 30'h3FFF_FFFF);
        send_cmd(wht_pkg::OP_READ,  10'd0,    30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd1023, 30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd512,  30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd1,    30'd0);
        send_cmd(wht_pkg::OP_XFORM, 10'd0,    30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd0,    30'd0);
        send_cmd(wht_pkg::OP_READ,  10'd2,    30'd0);
        send_cmd(wht_pkg::OP_WRITE, 10'd1023, 30'h2AAA_AAAA);
        send_cmd(wht_pkg::OP_READ,  10'd1023, 30'd0);

        xforms_left = XFORM_BUDGET;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    long_hold_req = 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                pick = $urandom_range(99);
                idx  = wht_pkg::INDEX_W'($urandom_range(wht_pkg::DEPTH - 1));
                val  = wht_pkg::DATA_W'($urandom());
                if (pick < 3 && xforms_left > 0)
                begin
                    xforms_left--;
                    send_cmd(wht_pkg::OP_XFORM, idx, val);
                end
                else if (pick < 50)
                begin
                    // values around the modulus or the top of the range now and then
                    case ($urandom_range(7))
                        0: val = wht_pkg::MODULUS - 30'($urandom_range(3));
                        1: val = wht_pkg::MODULUS + 30'($urandom_range(3));
                        2: val = 30'h3FFF_FFFF - 30'($urandom_range(3));
                        default: ;
                    endcase
                    written.push_back(idx);
                    if (written.size() > 64)
                        void'(written.pop_front());
                    send_cmd(wht_pkg::OP_WRITE, idx, val);
                end
                else if (pick < 93)
                begin
                    if (written.size() > 0 && $urandom_range(1) == 1)
                        idx = written[$urandom_range(written.size() - 1)];
                    send_cmd(wht_pkg::OP_READ, idx, val);
                end
                else
                    send_cmd(OP_UNUSED, idx, val);
            end
        end
        in_valid <= 1'b0;

        while (results.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (results.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/wht_pkg.sv
rtl/wht_ram.sv
rtl/wht_datapath.sv
rtl/wht_ctrl.sv
rtl/walsh_hadamard_transform_mod.sv
tb/walsh_hadamard_transform_mod_tb.sv
